// File: design/string_literal_escape_decoder_macros.svh
// Assertion macros shared by the string literal decoder modules.
`ifndef STRING_LITERAL_ESCAPE_DECODER_MACROS_SVH
`define STRING_LITERAL_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SLED_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sled assertion failed");

// Next-cycle implication, checked out of reset.
`define SLED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sled assertion failed");

`endif

// File: design/sled_pkg.sv
`default_nettype none

package sled_pkg;

  // Characters with a special meaning inside a literal.
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_HEX_MARK  = 8'h78;
  localparam logic [7:0] CH_ESCAPE    = 8'h1b;

  // Scanner modes, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_BODY = 5'b00010,
    MODE_ESC  = 5'b00100,
    MODE_HEX1 = 5'b01000,
    MODE_HEX2 = 5'b10000
  } mode_t;

  // Fault codes carried with a result.
  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_NEWLINE = 2'd1,
    FAULT_HEX     = 2'd2,
    FAULT_END     = 2'd3
  } fault_t;

  // One source request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       literal_done;
    fault_t     fault_code;
  } res_t;

  // White space is the space and tab through carriage return.
  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Returns {digit_ok, nibble} for one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_digit = {1'b1, d[3:0]};
    end else begin
      hex_digit = 5'b0_0000;
    end
  endfunction

  // Byte for a single-character escape; others stand for themselves.
  function automatic logic [7:0] escape_byte(input logic [7:0] c);
    case (c)
      8'h61:   escape_byte = 8'h07;
      8'h62:   escape_byte = 8'h08;
      8'h66:   escape_byte = 8'h0c;
      8'h6e:   escape_byte = 8'h0a;
      8'h72:   escape_byte = 8'h0d;
      8'h74:   escape_byte = 8'h09;
      8'h76:   escape_byte = 8'h0b;
      8'h65:   escape_byte = CH_ESCAPE;
      default: escape_byte = c;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: design/string_literal_escape_decoder.sv
// A byte accepted into the input register is decoded by the scanner and, when it
// moves on, its result is captured in the result register, where it is offered.
// Throughput: one byte per cycle; the scanner decides each byte combinationally.
// A full result register that is not taken stalls the input register behind it.
// Reset (rst, synchronous) empties both registers and returns the scanner to
// idle with the saved hex nibble cleared.
`default_nettype none

`include "string_literal_escape_decoder_macros.svh"

module string_literal_escape_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_mark,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            literal_done,
  output logic [1:0]      fault_code
);
  import sled_pkg::*;

  logic  held_valid;
  item_t held_item;
  logic  advance;
  logic  has_res;
  res_t  res;

  // The held byte moves on when the result register can take a request.
  assign advance = held_valid && (!out_valid || out_ready);

  sled_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .end_mark   (end_mark),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sled_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (held_item),
    .has_res (has_res),
    .res     (res)
  );

  sled_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && has_res),
    .res          (res),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .literal_done (literal_done),
    .fault_code   (fault_code)
  );

  // A stalled result with a byte waiting must block the input.
  `SLED_ASSERT_NOW(a_stall_blocks, clk, rst,
    held_valid && out_valid && !out_ready, !in_ready)
  // A result never carries both a byte and an end or fault indication.
  `SLED_ASSERT_NOW(a_res_exclusive, clk, rst,
    out_valid && byte_valid, !literal_done && fault_code == FAULT_NONE)

endmodule

`default_nettype wire

// File: design/sled_in_stage.sv
`default_nettype none

module sled_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          end_mark,
  input  wire logic          advance,
  output logic               held_valid,
  output sled_pkg::item_t    held_item
);
  import sled_pkg::*;

  // The register frees up in the same cycle its request moves on.
  assign in_ready = !held_valid || advance;

  // Occupancy of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Source byte capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item.in_byte  <= in_byte;
      held_item.end_mark <= end_mark;
    end
  end

endmodule

`default_nettype wire

// File: design/sled_decode.sv
`default_nettype none

`include "string_literal_escape_decoder_macros.svh"

module sled_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire sled_pkg::item_t item,
  output logic               has_res,
  output sled_pkg::res_t     res
);
  import sled_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic [4:0] hex;

  assign hex = hex_digit(item.in_byte);

  // Scanner transition and result for the held byte.
  always_comb begin
    mode_next        = mode;
    high_nibble_next = high_nibble;
    has_res          = 1'b0;
    res              = '{out_byte: 8'h00, byte_valid: 1'b0, literal_done: 1'b0,
                         fault_code: FAULT_NONE};
    case (mode)
      MODE_BODY: begin
        has_res = 1'b1;
        if (item.end_mark) begin
          res.fault_code = FAULT_END;
        end else if (item.in_byte == CH_BACKSLASH) begin
          has_res   = 1'b0;
          mode_next = MODE_ESC;
        end else if (item.in_byte == CH_QUOTE) begin
          res.literal_done = 1'b1;
        end else if (item.in_byte == CH_NEWLINE) begin
          res.fault_code = FAULT_NEWLINE;
        end else begin
          res.out_byte   = item.in_byte;
          res.byte_valid = 1'b1;
        end
      end
      MODE_ESC: begin
        has_res = 1'b1;
        if (item.end_mark) begin
          res.fault_code = FAULT_END;
        end else if (item.in_byte == CH_HEX_MARK) begin
          has_res   = 1'b0;
          mode_next = MODE_HEX1;
        end else begin
          res.out_byte   = escape_byte(item.in_byte);
          res.byte_valid = 1'b1;
          mode_next      = MODE_BODY;
        end
      end
      MODE_HEX1: begin
        if (item.end_mark) begin
          has_res        = 1'b1;
          res.fault_code = FAULT_END;
        end else if (!hex[4]) begin
          has_res        = 1'b1;
          res.fault_code = FAULT_HEX;
        end else begin
          high_nibble_next = hex[3:0];
          mode_next        = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        has_res = 1'b1;
        if (item.end_mark) begin
          res.fault_code = FAULT_END;
        end else if (!hex[4]) begin
          res.fault_code = FAULT_HEX;
        end else begin
          res.out_byte     = {high_nibble, hex[3:0]};
          res.byte_valid   = 1'b1;
          high_nibble_next = 4'h0;
          mode_next        = MODE_BODY;
        end
      end
      default: begin
        // Idle: skip white space and end markers; anything else opens.
        if (item.end_mark || is_blank(item.in_byte)) begin
          mode_next = MODE_IDLE;
        end else begin
          mode_next = MODE_BODY;
        end
      end
    endcase
    // A fault or the closing quote sends the scanner back to idle.
    if (res.fault_code != FAULT_NONE || res.literal_done) begin
      mode_next        = MODE_IDLE;
      high_nibble_next = 4'h0;
    end
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      high_nibble <= 4'h0;
    end else if (step) begin
      mode        <= mode_next;
      high_nibble <= high_nibble_next;
    end
  end

  // The saved nibble only lives between the two hex digits.
  `SLED_ASSERT_NOW(a_nibble_clear, clk, rst, mode != MODE_HEX2, high_nibble == 4'h0)
  // Faults and closing quotes always leave the scanner idle.
  `SLED_ASSERT_NEXT(a_end_to_idle, clk, rst,
    step && (res.fault_code != FAULT_NONE || res.literal_done), mode == MODE_IDLE)

endmodule

`default_nettype wire

// File: design/sled_out_stage.sv
`default_nettype none

module sled_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire sled_pkg::res_t res,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               literal_done,
  output logic [1:0]         fault_code
);
  import sled_pkg::*;

  res_t held;

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result capture.
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_byte     = held.out_byte;
  assign byte_valid   = held.byte_valid;
  assign literal_done = held.literal_done;
  assign fault_code   = held.fault_code;

endmodule

`default_nettype wire

// File: tb/sv/string_literal_escape_decoder_tb.sv
`default_nettype none

module string_literal_escape_decoder_tb;
  import sled_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 175;
  localparam int DRAIN_CYCLES = 8;

  // How a directed row is checked: against the predictor, as silent with no result, or by a typed result.
  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_SILENT  = 2'd1,
    ROW_RESULT  = 2'd2
  } row_kind_t;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       src_end;
    row_kind_t  kind;
    res_t       res;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_mark = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       literal_done;
  logic [1:0] fault_code;

  // Predictor state: scanner mode and the pending high nibble of a hex escape.
  mode_t      scan_state = MODE_IDLE;
  logic [3:0] saved_nibble = 4'h0;

  res_t      decoded_q[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        work_items = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  string     esc_letters = "'\"\\abfnrtve";

  string_literal_escape_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .end_mark    (end_mark),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .literal_done(literal_done),
    .fault_code  (fault_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic bit is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Value of one hex digit, or -1 when the byte is not a hex digit.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] escape_value(input logic [7:0] c);
    case (c)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "f":     return 8'h0c;
      "n":     return 8'h0a;
      "r":     return 8'h0d;
      "t":     return 8'h09;
      "v":     return 8'h0b;
      "e":     return CH_ESCAPE;
      default: return c;
    endcase
  endfunction

  // Drops the literal in progress and yields a result carrying the given fault.
  function automatic res_t abort_literal(input fault_t f);
    res_t r;
    r = '0;
    r.fault_code = f;
    scan_state = MODE_IDLE;
    saved_nibble = 4'h0;
    return r;
  endfunction

  // Advances the predicted scanner by one source byte; returns 1 when a result is due.
  function automatic bit predict_decode(input logic [7:0] c, input logic e, output res_t r);
    int h;
    r = '0;
    predict_decode = 1'b0;
    h = hex_nibble(c);
    case (scan_state)
      MODE_BODY: begin
        predict_decode = 1'b1;
        if (e) begin
          r = abort_literal(FAULT_END);
        end else if (c == CH_BACKSLASH) begin
          scan_state = MODE_ESC;
          predict_decode = 1'b0;
        end else if (c == CH_QUOTE) begin
          r = abort_literal(FAULT_NONE);
          r.literal_done = 1'b1;
        end else if (c == CH_NEWLINE) begin
          r = abort_literal(FAULT_NEWLINE);
        end else begin
          r.out_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      MODE_ESC: begin
        predict_decode = 1'b1;
        if (e) begin
          r = abort_literal(FAULT_END);
        end else if (c == CH_HEX_MARK) begin
          scan_state = MODE_HEX1;
          predict_decode = 1'b0;
        end else begin
          r.out_byte = escape_value(c);
          r.byte_valid = 1'b1;
          scan_state = MODE_BODY;
        end
      end
      MODE_HEX1: begin
        if (e) begin
          predict_decode = 1'b1;
          r = abort_literal(FAULT_END);
        end else if (h < 0) begin
          predict_decode = 1'b1;
          r = abort_literal(FAULT_HEX);
        end else begin
          saved_nibble = h[3:0];
          scan_state = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        predict_decode = 1'b1;
        if (e) begin
          r = abort_literal(FAULT_END);
        end else if (h < 0) begin
          r = abort_literal(FAULT_HEX);
        end else begin
          r.out_byte = {saved_nibble, h[3:0]};
          r.byte_valid = 1'b1;
          saved_nibble = 4'h0;
          scan_state = MODE_BODY;
        end
      end
      default: begin
        // Idle: white space and end markers are skipped, anything else opens a literal.
        scan_state = MODE_IDLE;
        if (!e && !is_space(c)) scan_state = MODE_BODY;
      end
    endcase
  endfunction

  function automatic logic [7:0] random_hex_digit();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(int'("0") + v);
    if ($urandom_range(1) == 0) return 8'(int'("a") + v - 10);
    return 8'(int'("A") + v - 10);
  endfunction

  task automatic add_row(input logic [7:0] b, input logic e, input row_kind_t kind,
                         input logic [7:0] ob, input logic bv, input logic ld,
                         input fault_t fc);
    stim_row_t row;
    row.src_byte = b;
    row.src_end = e;
    row.kind = kind;
    row.res.out_byte = ob;
    row.res.byte_valid = bv;
    row.res.literal_done = ld;
    row.res.fault_code = fc;
    directed_rows.push_back(row);
  endtask

  // Offers one source request after a random gap and records what it should produce.
  task automatic feed_byte(input logic [7:0] b, input logic e, input row_kind_t kind,
                           input res_t typed);
    res_t r;
    bit   produced;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    end_mark <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    work_items++;
    produced = predict_decode(b, e, r);
    if (kind == ROW_RESULT) decoded_q.push_back(typed);
    else if (kind == ROW_PREDICT && produced) decoded_q.push_back(r);
  endtask

  // One literal with random content; now and then broken, or plain noise instead.
  task automatic send_literal();
    logic [7:0] c;
    int         body_len;
    int         pick;
    int         depth;
    bit         broken;
    broken = 1'b0;
    if ($urandom_range(19) == 0) begin
      repeat ($urandom_range(1, 4))
        feed_byte(8'($urandom), $urandom_range(3) == 0, ROW_PREDICT, '0);
      return;
    end
    repeat ($urandom_range(2)) begin
      c = ($urandom_range(5) == 0) ? 8'h20 : 8'(8'h09 + $urandom_range(4));
      feed_byte(c, 1'b0, ROW_PREDICT, '0);
    end
    // Any byte that is not white space opens the literal.
    if ($urandom_range(7) == 0) begin
      do c = 8'($urandom); while (is_space(c));
    end else begin
      c = CH_QUOTE;
    end
    feed_byte(c, 1'b0, ROW_PREDICT, '0);
    body_len = $urandom_range(10);
    for (int k = 0; k < body_len && !broken; k++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        do c = 8'($urandom); while (c == CH_BACKSLASH || c == CH_QUOTE || c == CH_NEWLINE);
        feed_byte(c, 1'b0, ROW_PREDICT, '0);
      end else if (pick < 75) begin
        feed_byte(CH_BACKSLASH, 1'b0, ROW_PREDICT, '0);
        if ($urandom_range(3) == 0) begin
          do c = 8'($urandom); while (c == CH_HEX_MARK);
        end else begin
          c = esc_letters[$urandom_range(esc_letters.len() - 1)];
        end
        feed_byte(c, 1'b0, ROW_PREDICT, '0);
      end else if (pick < 96) begin
        feed_byte(CH_BACKSLASH, 1'b0, ROW_PREDICT, '0);
        feed_byte(CH_HEX_MARK, 1'b0, ROW_PREDICT, '0);
        feed_byte(random_hex_digit(), 1'b0, ROW_PREDICT, '0);
        feed_byte(random_hex_digit(), 1'b0, ROW_PREDICT, '0);
      end else begin
        broken = 1'b1;
        case ($urandom_range(2))
          0: feed_byte(CH_NEWLINE, 1'b0, ROW_PREDICT, '0);
          1: begin
            feed_byte(CH_BACKSLASH, 1'b0, ROW_PREDICT, '0);
            feed_byte(CH_HEX_MARK, 1'b0, ROW_PREDICT, '0);
            if ($urandom_range(1) == 0) feed_byte(random_hex_digit(), 1'b0, ROW_PREDICT, '0);
            do c = 8'($urandom); while (hex_nibble(c) >= 0);
            feed_byte(c, 1'b0, ROW_PREDICT, '0);
          end
          default: begin
            // End of input in the body, after a backslash, or inside a hex escape.
            depth = $urandom_range(3);
            if (depth >= 1) feed_byte(CH_BACKSLASH, 1'b0, ROW_PREDICT, '0);
            if (depth >= 2) feed_byte(CH_HEX_MARK, 1'b0, ROW_PREDICT, '0);
            if (depth >= 3) feed_byte(random_hex_digit(), 1'b0, ROW_PREDICT, '0);
            feed_byte(8'($urandom), 1'b1, ROW_PREDICT, '0);
          end
        endcase
      end
    end
    if (!broken) begin
      if ($urandom_range(15) == 0) feed_byte(8'($urandom), 1'b1, ROW_PREDICT, '0);
      else feed_byte(CH_QUOTE, 1'b0, ROW_PREDICT, '0);
      if ($urandom_range(5) == 0) feed_byte(8'($urandom), 1'b1, ROW_PREDICT, '0);
    end
  endtask

  // Result side: random back-pressure and an in-order compare against the expectations.
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result request: out_byte %02h fault_code %0d", out_byte, fault_code);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
            mismatches++;
          end
          if (byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
            mismatches++;
          end
          if (literal_done !== want.literal_done) begin
            $error("literal_done: expected %0b, got %0b", want.literal_done, literal_done);
            mismatches++;
          end
          if (fault_code !== want.fault_code) begin
            $error("fault_code: expected %0d, got %0d", want.fault_code, fault_code);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("string_literal_escape_decoder regression: fail");
      $finish;
    end
  end

  initial begin
    int phase;

    // Directed rows: white space and end marker after reset, byte extremes,
    // escapes, hex escapes, every fault, and an end marker after a closing quote.
    add_row(8'h20,        1'b0, ROW_SILENT,  8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(8'hff,        1'b1, ROW_SILENT,  8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_QUOTE,     1'b0, ROW_SILENT,  8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(8'h00,        1'b0, ROW_RESULT,  8'h00, 1'b1, 1'b0, FAULT_NONE);
    add_row(8'hff,        1'b0, ROW_RESULT,  8'hff, 1'b1, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("e",          1'b0, ROW_RESULT,  CH_ESCAPE, 1'b1, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_HEX_MARK,  1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("F",          1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("a",          1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_NEWLINE,   1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_HEX_MARK,  1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("g",          1'b0, ROW_RESULT,  8'h00, 1'b0, 1'b0, FAULT_HEX);
    add_row(8'h27,        1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_NEWLINE,   1'b0, ROW_RESULT,  8'h00, 1'b0, 1'b0, FAULT_NEWLINE);
    add_row(8'hff,        1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_HEX_MARK,  1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("0",          1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row("z",          1'b0, ROW_RESULT,  8'h00, 1'b0, 1'b0, FAULT_HEX);
    add_row(CH_QUOTE,     1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_BACKSLASH, 1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(8'h5a,        1'b1, ROW_RESULT,  8'h00, 1'b0, 1'b0, FAULT_END);
    add_row(CH_QUOTE,     1'b0, ROW_PREDICT, 8'h00, 1'b0, 1'b0, FAULT_NONE);
    add_row(CH_QUOTE,     1'b0, ROW_RESULT,  8'h00, 1'b0, 1'b1, FAULT_NONE);
    add_row(8'h00,        1'b1, ROW_SILENT,  8'h00, 1'b0, 1'b0, FAULT_NONE);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      feed_byte(directed_rows[i].src_byte, directed_rows[i].src_end, directed_rows[i].kind,
                directed_rows[i].res);
    end

    // Random literals across idle and back-pressure settings, two rounds.
    work_items = 0;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      while (work_items < (phase + 1) * PHASE_ITEMS) send_literal();
    end
    in_valid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("string_literal_escape_decoder regression: pass");
    end else begin
      $display("string_literal_escape_decoder regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
